// ===== hdl/c_rules_signed_integer_parser_defines.svh =====
// ----------------------------------------------------------------------------
// c_rules_signed_integer_parser_defines
// assertion macros used by the parse module
// ----------------------------------------------------------------------------
`ifndef C_RULES_SIGNED_INTEGER_PARSER_DEFINES_SVH
`define C_RULES_SIGNED_INTEGER_PARSER_DEFINES_SVH

// concurrent check, masked while reset is asserted
`define CSIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds across reset
`define CSIP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/csip_pkg.sv =====
// ----------------------------------------------------------------------------
// csip_pkg
// types, character codes and digit helpers for the signed integer parser
// ----------------------------------------------------------------------------
`default_nettype none

package csip_pkg;

  localparam int CharW = 8;
  localparam int ValW  = 64;

  // parse phase
  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // radix select
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  // ascii codes the prefix and sign logic looks for
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_X_LO  = 8'h78;
  localparam logic [CharW-1:0] CH_X_UP  = 8'h58;
  localparam logic [CharW-1:0] CH_B_LO  = 8'h62;
  localparam logic [CharW-1:0] CH_B_UP  = 8'h42;

  // one input character
  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             is_last;
  } char_item_t;

  // finished number, magnitude before sign is applied
  typedef struct packed {
    logic            is_valid;
    logic            neg;
    logic [ValW-1:0] mag;
  } fin_item_t;

  // classified character
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // map a character to its digit value, 0 to 15
  function automatic digit_t digit_of(input logic [CharW-1:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      d.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      d.val = 4'(c - 8'h37);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  // numeric radix of a select code
  function automatic logic [4:0] radix_value(input radix_t r);
    logic [4:0] v;
    case (r)
      RX_HEX:  v = 5'd16;
      RX_BIN:  v = 5'd2;
      RX_OCT:  v = 5'd8;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/csip_in_stage.sv =====
// ----------------------------------------------------------------------------
// csip_in_stage
// input register holding one character for the parse stage
// ----------------------------------------------------------------------------
`default_nettype none

module csip_in_stage (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_char_byte,
  input  wire logic                     in_is_last,
  output logic                          a_valid,
  output csip_pkg::char_item_t          a_item,
  input  wire logic                     a_stall
);
  import csip_pkg::*;

  logic       a_valid_r;
  char_item_t a_item_r;

  // hold only while a character sits here and the parser cannot take it
  assign in_stall = a_valid_r & a_stall;
  assign a_valid  = a_valid_r;
  assign a_item   = a_item_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  // character payload
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_item_r.char_byte <= in_char_byte;
      a_item_r.is_last   <= in_is_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csip_parse.sv =====
// ----------------------------------------------------------------------------
// csip_parse
// sign, prefix and digit state machine with the digit accumulator
// ----------------------------------------------------------------------------
`default_nettype none

`include "c_rules_signed_integer_parser_defines.svh"

module csip_parse (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     a_valid,
  input  wire csip_pkg::char_item_t     a_item,
  output logic                          a_stall,
  output logic                          fin_valid,
  output csip_pkg::fin_item_t           fin_item,
  input  wire logic                     fin_stall
);
  import csip_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic            par_r, par_nxt;
  radix_t          rx_r, rx_nxt;
  radix_t          rx_use;
  logic [ValW-1:0] acc_r, acc_nxt;
  logic [ValW-1:0] acc_scaled;
  logic            seen_r, seen_nxt;
  logic            bad_r, bad_nxt;
  logic            take;
  digit_t          dig;
  logic            dig_fits;
  logic            step;
  logic            fin_valid_r;
  fin_item_t       fin_r, fin_nxt;
  logic [CharW-1:0] c;

  assign c = a_item.char_byte;

  // a last character needs room in the finish register
  assign a_stall   = a_item.is_last & fin_valid_r & fin_stall;
  assign step      = a_valid & ~a_stall;
  assign fin_valid = fin_valid_r;
  assign fin_item  = fin_r;

  // digit classification against the radix in use
  assign dig      = digit_of(c);
  assign dig_fits = dig.ok & ({1'b0, dig.val} < radix_value(rx_use));

  // accumulator times radix plus digit
  always_comb begin
    case (rx_use)
      RX_HEX:  acc_scaled = {acc_r[ValW-5:0], dig.val};
      RX_OCT:  acc_scaled = {acc_r[ValW-4:0], dig.val[2:0]};
      RX_BIN:  acc_scaled = {acc_r[ValW-2:0], dig.val[0]};
      default: acc_scaled = {acc_r[ValW-4:0], 3'b000} + {acc_r[ValW-2:0], 1'b0}
                            + {{(ValW-4){1'b0}}, dig.val};
    endcase
  end

  // next parse state
  always_comb begin
    phase_nxt = phase_r;
    par_nxt   = par_r;
    rx_nxt    = rx_r;
    rx_use    = rx_r;
    take      = 1'b0;
    case (phase_r)
      PH_SIGN: begin
        if (c == CH_MINUS) begin
          par_nxt = ~par_r;
        end else if (c != CH_PLUS) begin
          if (c == CH_ZERO) begin
            phase_nxt = PH_ZERO;
          end else begin
            rx_nxt    = RX_DEC;
            rx_use    = RX_DEC;
            phase_nxt = PH_DIGITS;
            take      = 1'b1;
          end
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (c == CH_X_LO || c == CH_X_UP) begin
          rx_nxt = RX_HEX;
        end else if (c == CH_B_LO || c == CH_B_UP) begin
          rx_nxt = RX_BIN;
        end else begin
          rx_nxt = RX_OCT;
          rx_use = RX_OCT;
          take   = 1'b1;
        end
      end
      default: begin
        take = 1'b1;
      end
    endcase
  end

  // digit bookkeeping
  always_comb begin
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    bad_nxt  = bad_r;
    if (take) begin
      seen_nxt = 1'b1;
      if (dig_fits) begin
        acc_nxt = acc_scaled;
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  // finished number on the last character
  always_comb begin
    fin_nxt.neg      = par_nxt;
    fin_nxt.is_valid = 1'b0;
    fin_nxt.mag      = '0;
    case (phase_nxt)
      PH_SIGN: begin
        fin_nxt.is_valid = 1'b0;
      end
      PH_ZERO: begin
        fin_nxt.is_valid = 1'b1;
      end
      default: begin
        fin_nxt.is_valid = seen_nxt & ~bad_nxt;
        fin_nxt.mag      = (seen_nxt & ~bad_nxt) ? acc_nxt : '0;
      end
    endcase
  end

  // parse state, back to start after each last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIGN;
      par_r   <= 1'b0;
      rx_r    <= RX_DEC;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else if (step) begin
      if (a_item.is_last) begin
        phase_r <= PH_SIGN;
        par_r   <= 1'b0;
        rx_r    <= RX_DEC;
        acc_r   <= '0;
        seen_r  <= 1'b0;
        bad_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        par_r   <= par_nxt;
        rx_r    <= rx_nxt;
        acc_r   <= acc_nxt;
        seen_r  <= seen_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

  // finish register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (step && a_item.is_last) begin
      fin_valid_r <= 1'b1;
    end else if (!fin_stall) begin
      fin_valid_r <= 1'b0;
    end
  end

  // finish register payload
  always_ff @(posedge clk) begin
    if (step && a_item.is_last) begin
      fin_r <= fin_nxt;
    end
  end

  // checks
  `CSIP_ASSERT(a_restart, (step && a_item.is_last) |=> (phase_r == PH_SIGN && acc_r == '0 && !par_r && !seen_r && !bad_r), "parser did not restart after last character")
  `CSIP_ASSERT(a_seen_phase, seen_r |-> (phase_r == PH_DIGITS), "digit seen outside digit phase")
  `CSIP_ASSERT(a_acc_idle, (phase_r != PH_DIGITS) |-> (acc_r == '0 && !bad_r), "accumulator busy before digit phase")
  `CSIP_ASSERT(a_invalid_zero, (fin_valid_r && !fin_r.is_valid) |-> (fin_r.mag == '0), "invalid number carries a value")
  `CSIP_ASSERT_RST(a_reset_empty, !rst_n |=> !fin_valid_r, "finish register not empty after reset")

endmodule

`default_nettype wire

// ===== hdl/csip_out_stage.sv =====
// ----------------------------------------------------------------------------
// csip_out_stage
// applies the sign and holds the result for the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module csip_out_stage (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fin_valid,
  input  wire csip_pkg::fin_item_t      fin_item,
  output logic                          fin_stall,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_is_valid,
  output logic signed [63:0]            out_value
);
  import csip_pkg::*;

  logic                   out_valid_r;
  logic                   is_valid_r;
  logic signed [ValW-1:0] value_r, value_nxt;
  logic                   load;

  assign fin_stall    = out_valid_r & out_stall;
  assign load         = fin_valid & ~fin_stall;
  assign out_valid    = out_valid_r;
  assign out_is_valid = is_valid_r;
  assign out_value    = value_r;

  // two's complement negate when the count of minus signs is odd
  assign value_nxt = fin_item.neg ? signed'({ValW{1'b0}} - fin_item.mag)
                                  : signed'(fin_item.mag);

  // output occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!fin_stall) begin
      out_valid_r <= fin_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      is_valid_r <= fin_item.is_valid;
      value_r    <= value_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/c_rules_signed_integer_parser.sv =====
// Streaming signed integer parser with C literal rules. Characters arrive one per transfer,
// the last one flagged by in_is_last; leading '+'/'-' set the sign, a 0x, 0b or 0 prefix
// picks hex, binary or octal, otherwise decimal. The block takes one character every cycle
// unless in_stall holds it (a last character waits while the finish register is held full):
// each character passes an input register, then one update of the parse state and
// accumulator (a shift for hex/octal/binary, shift-and-add for decimal) by the single
// 64-bit multiply-accumulate. The result of a number (is_valid and the 64-bit wrapped value,
// zero when invalid) passes the finish register, then is negated into the output register.
// ----------------------------------------------------------------------------
// c_rules_signed_integer_parser
// top level: input register, parse stage, sign and output register
// ----------------------------------------------------------------------------
`default_nettype none

module c_rules_signed_integer_parser (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_char_byte,
  input  wire logic                     in_is_last,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_is_valid,
  output logic signed [63:0]            out_value
);
  import csip_pkg::*;

  logic       a_valid;
  char_item_t a_item;
  logic       a_stall;
  logic       fin_valid;
  fin_item_t  fin_item;
  logic       fin_stall;

  // character input register
  csip_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_is_last   (in_is_last),
    .a_valid      (a_valid),
    .a_item       (a_item),
    .a_stall      (a_stall)
  );

  // sign, prefix and digit parsing
  csip_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_valid   (a_valid),
    .a_item    (a_item),
    .a_stall   (a_stall),
    .fin_valid (fin_valid),
    .fin_item  (fin_item),
    .fin_stall (fin_stall)
  );

  // sign and result register
  csip_out_stage u_out_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .fin_valid    (fin_valid),
    .fin_item     (fin_item),
    .fin_stall    (fin_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_valid (out_is_valid),
    .out_value    (out_value)
  );

endmodule

`default_nettype wire

// ===== sim/c_rules_signed_integer_parser_tb.sv =====
// ----------------------------------------------------------------------------
// c_rules_signed_integer_parser_tb
// feeds number text one byte per transfer and checks every parsed result
// against a predictor of the sign, prefix and digit rules, with random idle
// bursts on the sender and random stall bursts on the receiver
// ----------------------------------------------------------------------------
module c_rules_signed_integer_parser_tb;
  import csip_pkg::*;

  // digit characters not covered by the package
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_G_LO = 8'h67;

  localparam int TargetChars = 1375;
  localparam int CalmChars   = 150;

  typedef struct packed {
    logic        is_valid;
    logic [63:0] value;
  } parse_result_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = '0;
  logic        in_is_last   = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        out_is_valid;
  logic signed [63:0] out_value;

  char_item_t    pending_chars[$];
  parse_result_t expected_numbers[$];

  int   total_chars   = 0;
  int   chars_taken   = 0;
  int   numbers_seen  = 0;
  int   mismatches    = 0;
  int   in_gap_left   = 0;
  int   out_stall_left = 0;
  int   in_idle_pct   = 10;
  int   out_stall_pct = 10;
  logic calm          = 1'b0;

  // predictor state
  phase_t      scan_phase;
  logic        minus_odd;
  radix_t      base_sel;
  logic [63:0] digit_acc;
  logic        saw_digit;
  logic        saw_bad;

  c_rules_signed_integer_parser DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_valid (out_is_valid),
    .out_value    (out_value)
  );

  always #6 clk = ~clk;

  function automatic void clear_parse_state();
    scan_phase = PH_SIGN;
    minus_odd  = 1'b0;
    base_sel   = RX_DEC;
    digit_acc  = '0;
    saw_digit  = 1'b0;
    saw_bad    = 1'b0;
  endfunction

  // one digit position: accumulate if it fits the radix, else mark bad
  function automatic void take_digit(input logic [7:0] c);
    logic [4:0] base;
    logic [4:0] d;
    case (base_sel)
      RX_HEX:  base = 5'd16;
      RX_BIN:  base = 5'd2;
      RX_OCT:  base = 5'd8;
      default: base = 5'd10;
    endcase
    d = 5'd31;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 5'(c - CH_ZERO);
    end else if (c >= CH_A_LO && c <= CH_A_LO + 8'd5) begin
      d = 5'(c - CH_A_LO + 8'd10);
    end else if (c >= CH_A_UP && c <= CH_A_UP + 8'd5) begin
      d = 5'(c - CH_A_UP + 8'd10);
    end
    saw_digit = 1'b1;
    if (d < base) begin
      digit_acc = digit_acc * base + 64'(d);
    end else begin
      saw_bad = 1'b1;
    end
  endfunction

  // advance the parse by one character, produce a number on the last one
  function automatic void predict_char(input logic [7:0] c, input logic last,
                                       output logic done, output parse_result_t res);
    case (scan_phase)
      PH_SIGN: begin
        if (c == CH_MINUS) begin
          minus_odd = ~minus_odd;
        end else if (c != CH_PLUS) begin
          if (c == CH_ZERO) begin
            scan_phase = PH_ZERO;
          end else begin
            base_sel   = RX_DEC;
            scan_phase = PH_DIGITS;
            take_digit(c);
          end
        end
      end
      PH_ZERO: begin
        scan_phase = PH_DIGITS;
        if (c == CH_X_LO || c == CH_X_UP) begin
          base_sel = RX_HEX;
        end else if (c == CH_B_LO || c == CH_B_UP) begin
          base_sel = RX_BIN;
        end else begin
          base_sel = RX_OCT;
          take_digit(c);
        end
      end
      default: take_digit(c);
    endcase
    done = last;
    res  = '0;
    if (last) begin
      case (scan_phase)
        PH_SIGN: res.is_valid = 1'b0;
        PH_ZERO: res.is_valid = 1'b1;
        default: begin
          res.is_valid = saw_digit && !saw_bad;
          res.value    = res.is_valid ? digit_acc : 64'd0;
        end
      endcase
      if (minus_odd) res.value = -res.value;
      clear_parse_state();
    end
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 4))
      0, 1:    return 0;
      2:       return 5;
      3:       return 20;
      default: return 50;
    endcase
  endfunction

  function automatic void queue_number(input logic [7:0] txt[$]);
    foreach (txt[k]) pending_chars.push_back('{char_byte: txt[k], is_last: (k == txt.size() - 1)});
  endfunction

  function automatic void queue_text(input string s);
    logic [7:0] txt[$];
    for (int k = 0; k < s.len(); k++) txt.push_back(s[k]);
    queue_number(txt);
  endfunction

  // driver: predict on each accepted transfer, then pick the next payload
  always @(posedge clk) begin
    logic          done;
    parse_result_t res;
    char_item_t    nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_char(in_char_byte, in_is_last, done, res);
        if (done) expected_numbers.push_back(res);
        chars_taken++;
        if (chars_taken % 40 == 0) in_idle_pct = pick_idle_pct();
      end
      calm <= (pending_chars.size() < CalmChars);
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0 && !calm) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(1, 100) <= in_idle_pct) begin
          in_gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          nxt = pending_chars.pop_front();
          in_valid     <= 1'b1;
          in_char_byte <= nxt.char_byte;
          in_is_last   <= nxt.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_numbers.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: valid %0b value %0d", out_is_valid, out_value);
          mismatches++;
        end else begin
          want = expected_numbers.pop_front();
          if (out_is_valid !== want.is_valid || out_value !== want.value) begin
            if (mismatches < 10)
              $display("result %0d: expected valid %0b value %0d, got valid %0b value %0d",
                       numbers_seen, want.is_valid, $signed(want.value), out_is_valid,
                       out_value);
            mismatches++;
          end
        end
        numbers_seen++;
        if (numbers_seen % 12 == 0) out_stall_pct = pick_idle_pct();
      end
      if (out_stall_left > 0 && !calm) begin
        out_stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(1, 100) <= out_stall_pct) begin
        out_stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [7:0] txt[$];
    string      s;
    int         kind;
    int         n;
    int         d;
    int         pos;
    radix_t     base;
    clear_parse_state();

    // directed: signs only, signed lone zero, bare prefixes, hex, octal and binary values
    queue_text("-");
    queue_text("+-0");
    queue_text("0x");
    queue_text("0B");
    queue_text("0xFf");
    queue_text("017");
    queue_text("0b1");
    // byte extremes and non-ascii bytes
    s = "7";
    s.putc(0, 8'hFF);
    queue_text(s);
    s = "12";
    s.putc(1, 8'h80);
    queue_text(s);
    s = "77";
    s.putc(1, 8'h7F);
    queue_text(s);
    txt.delete();
    txt.push_back(8'h00);
    queue_number(txt);
    // sign after digits
    queue_text("1-");

    // random numbers: mostly well formed, some broken, some noise
    while (pending_chars.size() < TargetChars) begin
      txt.delete();
      kind = $urandom_range(0, 99);
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      base = radix_t'($urandom_range(0, 3));
      case (base)
        RX_HEX: begin
          txt.push_back(CH_ZERO);
          txt.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
        end
        RX_BIN: begin
          txt.push_back(CH_ZERO);
          txt.push_back($urandom_range(0, 1) ? CH_B_LO : CH_B_UP);
        end
        RX_OCT:  txt.push_back(CH_ZERO);
        default: ;
      endcase
      // long digit runs can make the accumulator wrap
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 26) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        case (base)
          RX_HEX:  d = $urandom_range(0, 15);
          RX_BIN:  d = $urandom_range(0, 1);
          RX_OCT:  d = $urandom_range(0, 7);
          default: d = (k == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9);
        endcase
        if (d < 10) txt.push_back(CH_ZERO + 8'(d));
        else txt.push_back(($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(d - 10));
      end
      if (kind >= 70 && kind < 80) begin
        // one byte replaced by anything
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind >= 80 && kind < 88) begin
        // cut short, may leave only signs or a bare prefix
        n = $urandom_range(1, txt.size());
        txt = txt[0:n-1];
      end else if (kind >= 88 && kind < 94) begin
        // a digit just outside the radix
        pos = $urandom_range(0, txt.size());
        case (base)
          RX_HEX:  txt.insert(pos, CH_G_LO);
          RX_BIN:  txt.insert(pos, CH_ZERO + 8'd2);
          RX_OCT:  txt.insert(pos, CH_NINE);
          default: txt.insert(pos, CH_A_LO);
        endcase
      end else if (kind >= 94) begin
        txt.delete();
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) txt.push_back(8'($urandom_range(0, 255)));
      end
      queue_number(txt);
    end
    total_chars = pending_chars.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_taken < total_chars) @(posedge clk);
    while (expected_numbers.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_numbers.size() == 0) begin
      $display("c_rules_signed_integer_parser_tb: PASS");
    end else begin
      $display("c_rules_signed_integer_parser_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 600000);
    $display("c_rules_signed_integer_parser_tb: FAIL");
    $finish;
  end

endmodule
